FILE: rtl/tmrle_pkg.sv
// Shared types and constants for the tile map run-length encoder.
package tmrle_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [3:0] BOULDER_TILE = 4'hE;
    localparam logic [3:0] SPIDER_TILE  = 4'hF;
    localparam logic [3:0] MAX_EXTRA    = 4'hF;

    typedef struct packed {
        logic       last_of_run;
        logic [7:0] code_byte;
    } t_entry;

    typedef struct packed {
        logic [1:0] num;
        t_entry     ent0;
        t_entry     ent1;
    } t_push;

endpackage

FILE: rtl/tmrle_run_core.sv
// Run tracking state and per-item run decision.
module tmrle_run_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [3:0]         i_tile_code,
    input  logic               i_keep_single,
    input  logic               i_row_end,
    input  logic               i_boulder_runs,
    output tmrle_pkg::t_push   o_push
);
    import tmrle_pkg::*;

    logic       r_run_open;
    logic [3:0] r_run_tile;
    logic [3:0] r_run_extra;
    logic       n_run_open;
    logic [3:0] n_run_tile;
    logic [3:0] n_run_extra;

    logic [3:0] extra_inc;
    logic       joins;
    logic       lone;
    t_push      push;

    always_comb begin
        extra_inc   = r_run_extra + 4'd1;
        joins       = r_run_open && (i_tile_code == r_run_tile) && !i_keep_single;
        lone        = i_keep_single || i_row_end ||
                      (!i_boulder_runs &&
                       (i_tile_code == BOULDER_TILE || i_tile_code == SPIDER_TILE));
        n_run_open  = r_run_open;
        n_run_tile  = r_run_tile;
        n_run_extra = r_run_extra;
        push        = '0;
        if (joins) begin
            if (extra_inc == MAX_EXTRA || i_row_end) begin
                push.num  = 2'd1;
                push.ent0 = '{last_of_run: 1'b1, code_byte: {extra_inc, r_run_tile}};
                n_run_open  = 1'b0;
                n_run_extra = 4'd0;
            end else begin
                n_run_extra = extra_inc;
            end
        end else begin
            if (r_run_open) begin
                push.num  = 2'd1;
                push.ent0 = '{last_of_run: 1'b0, code_byte: {r_run_extra, r_run_tile}};
            end
            if (lone) begin
                n_run_open  = 1'b0;
                n_run_extra = 4'd0;
                if (r_run_open) begin
                    push.num  = 2'd2;
                    push.ent1 = '{last_of_run: 1'b1, code_byte: {4'd0, i_tile_code}};
                end else begin
                    push.num  = 2'd1;
                    push.ent0 = '{last_of_run: 1'b1, code_byte: {4'd0, i_tile_code}};
                end
            end else begin
                // close pending run on the last result it made
                if (r_run_open) begin
                    push.ent0.last_of_run = 1'b1;
                end
                n_run_open  = 1'b1;
                n_run_tile  = i_tile_code;
                n_run_extra = 4'd0;
            end
        end
        if (!i_fire) begin
            push = '0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_tile  <= 4'd0;
            r_run_extra <= 4'd0;
        end else if (i_fire) begin
            r_run_open  <= n_run_open;
            r_run_tile  <= n_run_tile;
            r_run_extra <= n_run_extra;
        end
    end

    a_open_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open |-> r_run_extra != MAX_EXTRA)
        else $error("pending run holds full count");

    a_closed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_open |-> r_run_extra == 4'd0)
        else $error("count kept without pending run");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.num == 2'd2 |-> !o_push.ent0.last_of_run && o_push.ent1.last_of_run &&
                               r_run_open)
        else $error("two results with wrong last marks");

    a_join_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && joins && !i_row_end && extra_inc != MAX_EXTRA) |-> o_push.num == 2'd0)
        else $error("result emitted while run continues");

endmodule

FILE: rtl/tmrle_out_fifo.sv
// Result queue taking up to two items per cycle and giving one.
module tmrle_out_fifo #(
    parameter int unsigned DEPTH = tmrle_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmrle_pkg::t_push   i_push,
    output logic               o_room,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_code_byte,
    output logic               o_last_of_run
);
    import tmrle_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = AW + 1;

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            pop;
    logic [AW-1:0]   wr_ptr_1;

    assign pop         = (r_count != '0) && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_room      = (r_count <= CW'(DEPTH - 2));
    assign wr_ptr_1    = r_wr_ptr + AW'(1);
    assign n_count     = r_count + CW'(i_push.num) - CW'(pop);

    assign o_code_byte   = r_mem[r_rd_ptr].code_byte;
    assign o_last_of_run = r_mem[r_rd_ptr].last_of_run;

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.ent0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.ent1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.num);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.num != 2'd0 |-> o_room)
        else $error("push without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_wr_ptr - r_rd_ptr) == r_count[AW-1:0])
        else $error("pointers disagree with count");

endmodule

FILE: rtl/tile_map_run_length_encoder_top.sv
// Top level of the tile map run-length encoder.
//
// Input channel: i_in_valid / o_in_stall with i_tile_code, i_keep_single,
// i_row_end; an item is taken at an edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_code_byte, o_last_of_run.
// Each item gives zero, one or two results; o_last_of_run marks the final
// result that an item causes.
// Config: i_cfg_we writes i_cfg_wdata to the boulder run enable (reset 0);
// write it only while the block is idle.
// Order: an item is registered at the input, decided against the run
// state once the result queue has room, and then pushed into the result
// queue; its first result shows on the output once the queue has stored
// it, and is taken at an edge with o_out_valid high and i_out_stall low.
// Throughput: one item per cycle while the result queue (FIFO_DEPTH entries,
// power of two, at least 4) keeps room for two results; items that give two
// results drain at one result per cycle while the receiver does not stall.
// Reset (synchronous, active low) closes any pending run, empties the queue
// and clears the boulder run enable. When the receiver stalls, results hold
// in the queue and o_in_stall rises once it cannot take another pair.
module tile_map_run_length_encoder_top #(
    parameter int unsigned FIFO_DEPTH = tmrle_pkg::FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_tile_code,
    input  logic       i_keep_single,
    input  logic       i_row_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run
);
    import tmrle_pkg::*;

    logic       r_compress;
    logic       r_in_valid;
    logic [3:0] r_tile_code;
    logic       r_keep_single;
    logic       r_row_end;
    logic       room;
    logic       fire;
    logic       accept;
    t_push      push;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_compress <= i_cfg_wdata;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tile_code   <= i_tile_code;
            r_keep_single <= i_keep_single;
            r_row_end     <= i_row_end;
        end
    end

    tmrle_run_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_tile_code    (r_tile_code),
        .i_keep_single  (r_keep_single),
        .i_row_end      (r_row_end),
        .i_boulder_runs (r_compress),
        .o_push         (push)
    );

    tmrle_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_room        (room),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: bench/tile_map_run_length_encoder_top_tb.sv
// Self-checking testbench for the tile map run-length encoder: a scoreboard predicts code bytes.
`timescale 1ns / 100ps

module tile_map_run_length_encoder_top_tb;
    import tmrle_pkg::*;

    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned LONG_HOLD      = 60;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_COUNT    = 6;
    localparam int unsigned PHASE_TILES    = 250;

    class run_code_board;
        bit          boulder_runs;
        bit          run_open;
        logic [3:0]  run_tile;
        logic [3:0]  run_extra;
        t_entry      expected_codes[$];
        int unsigned errors;
        int unsigned tiles_seen;
        int unsigned codes_checked;
        int unsigned double_items;
        int unsigned full_runs;
        int unsigned boulder_runs_opened;

        function void note_tile(logic [3:0] tile, logic single, logic row_end);
            t_entry made[$];
            t_entry e;
            bit     joined;
            joined = 1'b0;
            tiles_seen++;
            if (run_open) begin
                if (tile == run_tile && !single) begin
                    joined = 1'b1;
                    run_extra = run_extra + 4'd1;
                    if (run_extra == MAX_EXTRA || row_end) begin
                        if (run_extra == MAX_EXTRA) full_runs++;
                        e.last_of_run = 1'b0;
                        e.code_byte   = {run_extra, run_tile};
                        made = {made, e};
                        run_open  = 1'b0;
                        run_extra = 4'd0;
                    end
                end else begin
                    e.last_of_run = 1'b0;
                    e.code_byte   = {run_extra, run_tile};
                    made = {made, e};
                    run_open  = 1'b0;
                    run_extra = 4'd0;
                end
            end
            if (!joined) begin
                if (single || row_end ||
                    (!boulder_runs && (tile == BOULDER_TILE || tile == SPIDER_TILE))) begin
                    e.last_of_run = 1'b0;
                    e.code_byte   = {4'd0, tile};
                    made = {made, e};
                end else begin
                    if (tile == BOULDER_TILE || tile == SPIDER_TILE) boulder_runs_opened++;
                    run_open  = 1'b1;
                    run_tile  = tile;
                    run_extra = 4'd0;
                end
            end
            if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
            if (made.size() == 2) double_items++;
            expected_codes = {expected_codes, made};
        endfunction

        function void check_code(logic [7:0] code, logic last);
            t_entry want;
            codes_checked++;
            if (expected_codes.size() == 0) begin
                errors++;
                $display("%0t: unexpected code byte, actual code=%h last=%b", $time, code, last);
                return;
            end
            want = expected_codes.pop_front();
            if (code !== want.code_byte) begin
                errors++;
                $display("%0t: code_byte mismatch, expected %h actual %h",
                         $time, want.code_byte, code);
            end
            if (last !== want.last_of_run) begin
                errors++;
                $display("%0t: last_of_run mismatch, expected %b actual %b",
                         $time, want.last_of_run, last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [3:0] i_tile_code;
    logic       i_keep_single;
    logic       i_row_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_code_byte;
    logic       o_last_of_run;

    run_code_board board = new();
    bit            in_idle_on;
    bit            out_idle_on;
    bit            long_hold_req;
    int unsigned   cfg_writes;
    int unsigned   quiet_cycles;

    tile_map_run_length_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_tile_code   (i_tile_code),
        .i_keep_single (i_keep_single),
        .i_row_end     (i_row_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0)
                board.note_tile(i_tile_code, i_keep_single, i_row_end);
            if (o_out_valid === 1'b1 && !i_out_stall)
                board.check_code(o_code_byte, o_last_of_run);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_tile(input logic [3:0] tile, input logic single, input logic row_end);
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_tile_code   <= tile;
        i_keep_single <= single;
        i_row_end     <= row_end;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.expected_codes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_boulder_cfg(input bit value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        board.boulder_runs = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_tiles(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        logic [3:0]  tile;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 2) begin
                send_tile(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                tile = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(14, 15))
                                                   : 4'($urandom_range(0, 15));
                case ($urandom_range(0, 3))
                    0: len = $urandom_range(1, 3);
                    1: len = $urandom_range(4, 10);
                    2: len = $urandom_range(14, 18);
                    default: len = $urandom_range(1, 20);
                endcase
                for (int i = 0; i < len; i++) begin
                    send_tile(tile, $urandom_range(0, 19) == 0,
                              (i == len - 1) && ($urandom_range(0, 2) != 0));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        i_in_valid    = 1'b0;
        i_tile_code   = 4'd0;
        i_keep_single = 1'b0;
        i_row_end     = 1'b0;
        in_idle_on    = 1'b1;
        out_idle_on   = 1'b1;
        long_hold_req = 1'b0;
        cfg_writes    = 0;
        quiet_cycles  = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_boulder_cfg(1'b0);
        repeat (16) send_tile(4'd3, 1'b0, 1'b0);
        send_tile(4'd0, 1'b0, 1'b1);
        send_tile(BOULDER_TILE, 1'b0, 1'b0);
        send_tile(SPIDER_TILE, 1'b0, 1'b1);
        send_tile(4'd7, 1'b0, 1'b0);
        send_tile(4'd7, 1'b1, 1'b0);
        write_boulder_cfg(1'b1);
        send_tile(SPIDER_TILE, 1'b0, 1'b0);
        send_tile(SPIDER_TILE, 1'b0, 1'b0);
        write_boulder_cfg(1'b0);
        send_tile(SPIDER_TILE, 1'b0, 1'b0);
        send_tile(SPIDER_TILE, 1'b0, 1'b1);
        send_tile(4'd4, 1'b0, 1'b0);
        send_tile(4'd8, 1'b0, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_boulder_cfg((p % 2) == 0 ? 1'b1 : (p == 3));
            in_idle_on  = (p != 3) && (p != PHASE_COUNT - 1);
            out_idle_on = (p != 1) && (p != PHASE_COUNT - 1);
            if (p == 2) long_hold_req = 1'b1;
            send_random_tiles(PHASE_TILES);
        end

        wait_drained();
        $display("Run covered %0d tiles and %0d code bytes over %0d boulder setting writes.",
                 board.tiles_seen, board.codes_checked, cfg_writes);
        $display("Saw %0d tiles closing a run and emitting themselves,",
                 board.double_items);
        $display("%0d full runs, %0d boulder runs.",
                 board.full_runs, board.boulder_runs_opened);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
